FILE: rtl/core/tctt_pkg.sv
// ----------------------------------------------------------------------------
// tctt_pkg
// shared types, codes and sizes of the tick countdown timer table
// ----------------------------------------------------------------------------
package tctt_pkg;

  // table geometry
  localparam int TimerSlots  = 16;
  localparam int HandleCount = 16;
  localparam int SlotIdxW    = $clog2(TimerSlots);
  localparam int CountW      = $clog2(TimerSlots + 1);
  localparam int HandleW     = 4;

  // field widths
  localparam int ActionW   = 2;
  localparam int AmountW   = 32;
  localparam int UnitW     = 3;
  localparam int KindW     = 3;
  localparam int TickRateW = 14;
  localparam int TickW     = 32;
  localparam int ProdW     = AmountW + TickRateW;

  // reciprocal multiply for the ms and us divides, exact over any 32-bit product
  localparam int RecipProdW   = 2 * TickW;
  localparam int RecipMsShift = 38;
  localparam int RecipUsShift = 50;
  localparam logic [TickW-1:0] RecipMs = TickW'(274877907);
  localparam logic [TickW-1:0] RecipUs = TickW'(1125899907);

  // configuration port
  localparam int ApbDataW = 32;
  localparam int PaddrW   = 3;
  localparam logic RegTickRate = 1'b0;
  localparam logic [TickRateW-1:0] TickRateReset = TickRateW'(24);

  typedef enum logic [ActionW-1:0] {
    ACT_SCHEDULE = 2'd0,
    ACT_CANCEL   = 2'd1,
    ACT_TICK     = 2'd2
  } action_e;

  typedef enum logic [UnitW-1:0] {
    UNIT_TICKS = 3'd0,
    UNIT_SEC   = 3'd1,
    UNIT_MS    = 3'd2,
    UNIT_US    = 3'd3
  } unit_e;

  typedef enum logic [KindW-1:0] {
    KIND_SCHEDULED = 3'd0,
    KIND_REJECTED  = 3'd1,
    KIND_CANCELLED = 3'd2,
    KIND_NOT_FOUND = 3'd3,
    KIND_FIRED     = 3'd4,
    KIND_TICK_DONE = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_DIV,
    ST_APPEND,
    ST_WALK
  } ctrl_state_e;

  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic [TickW-1:0]   count;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic append;
    logic reject;
    logic walk;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [ActionW-1:0] act;
    logic               bad_unit;
    logic               full;
    logic               need_div;
    logic               walk_done;
  } sts_t;

endpackage

FILE: rtl/core/tctt_regs.sv
// ----------------------------------------------------------------------------
// tctt_regs
// apb-style register file holding the tick rate
// ----------------------------------------------------------------------------
module tctt_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tctt_pkg::PaddrW-1:0]    paddr,
  input  logic [tctt_pkg::ApbDataW-1:0]  pwdata,
  output logic [tctt_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready,
  output logic [tctt_pkg::TickRateW-1:0] tick_rate_o
);
  import tctt_pkg::*;

  logic [TickRateW-1:0] tick_rate_q, tick_rate_d;
  logic                 wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    tick_rate_d = tick_rate_q;
    if (wr_en && (paddr[2] == RegTickRate)) begin
      tick_rate_d = pwdata[TickRateW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_rate_q <= TickRateReset;
    end else begin
      tick_rate_q <= tick_rate_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegTickRate) begin
      prdata = ApbDataW'(tick_rate_q);
    end
  end

  assign tick_rate_o = tick_rate_q;

endmodule

FILE: rtl/core/tctt_ctrl.sv
// ----------------------------------------------------------------------------
// tctt_ctrl
// sequencing state machine for schedule, cancel and tick requests
// ----------------------------------------------------------------------------
module tctt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  tctt_pkg::sts_t sts_i,
  output tctt_pkg::cmd_t cmd_o
);
  import tctt_pkg::*;

  ctrl_state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (sts_i.act) inside
          ACT_SCHEDULE: begin
            state_d = (sts_i.bad_unit || sts_i.full) ? ST_IDLE : ST_MUL;
          end
          ACT_CANCEL, ACT_TICK: state_d = ST_WALK;
          default:              state_d = ST_IDLE;
        endcase
      end
      ST_MUL: begin
        state_d = sts_i.need_div ? ST_DIV : ST_APPEND;
      end
      ST_DIV:    state_d = ST_APPEND;
      ST_APPEND: state_d = ST_IDLE;
      ST_WALK: begin
        if (sts_i.walk_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE:     cmd_o.load = start;
      ST_DECODE: begin
        unique case (sts_i.act) inside
          ACT_SCHEDULE:         cmd_o.reject = sts_i.bad_unit || sts_i.full;
          ACT_CANCEL, ACT_TICK: cmd_o.reject = 1'b0;
          default:              cmd_o.reject = 1'b1;
        endcase
      end
      ST_MUL:      cmd_o.mul = 1'b1;
      ST_DIV:      cmd_o.div = 1'b1;
      ST_APPEND:   cmd_o.append = 1'b1;
      ST_WALK: begin
        cmd_o.walk   = 1'b1;
        cmd_o.finish = sts_i.walk_done;
      end
      default:     cmd_o = '0;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/tctt_dp.sv
// ----------------------------------------------------------------------------
// tctt_dp
// slot memory, handle allocation, unit conversion and result register
// ----------------------------------------------------------------------------
module tctt_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tctt_pkg::cmd_t                 cmd_i,
  output tctt_pkg::sts_t                 sts_o,
  input  logic [tctt_pkg::TickRateW-1:0] tick_rate_i,
  input  logic [tctt_pkg::ActionW-1:0]   action_i,
  input  logic [tctt_pkg::AmountW-1:0]   amount_i,
  input  logic [tctt_pkg::UnitW-1:0]     unit_i,
  input  logic [tctt_pkg::HandleW-1:0]   cancel_handle_i,
  output logic                           out_strobe_o,
  output logic [tctt_pkg::KindW-1:0]     kind_o,
  output logic [tctt_pkg::HandleW-1:0]   handle_o,
  output logic                           last_o
);
  import tctt_pkg::*;

  // latched request
  logic [ActionW-1:0] act_q;
  logic [AmountW-1:0] amount_q;
  logic [UnitW-1:0]   unit_q;
  logic [HandleW-1:0] chandle_q;

  // conversion
  logic [ProdW-1:0]      prod_q;
  logic [TickW-1:0]      prod_sat;
  logic [TickW-1:0]      recip;
  logic [RecipProdW-1:0] recip_prod;
  logic [TickW-1:0]      quo_q, quo_d;
  logic [TickW-1:0]      ticks;

  // table state
  entry_t                mem [TimerSlots];
  entry_t                rd_entry_q;
  logic                  rd_en;
  logic                  mem_we;
  logic [SlotIdxW-1:0]   mem_waddr;
  entry_t                mem_wdata;
  logic [CountW-1:0]     live_q, live_d;
  logic [HandleCount-1:0] busy_q, busy_d;
  logic [HandleW-1:0]    free_h;

  // walk pointers
  logic [CountW-1:0] r_q, r_d, w_q, w_d;
  logic              pv_q, pv_d;
  logic              found_q, found_d;

  // result register
  logic               out_valid_q, out_valid_d;
  logic [KindW-1:0]   kind_q, kind_d;
  logic [HandleW-1:0] handle_q, handle_d;
  logic               last_q, last_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q     <= action_i;
      amount_q  <= amount_i;
      unit_q    <= unit_i;
      chandle_q <= cancel_handle_i;
    end
    if (cmd_i.mul) begin
      prod_q <= ProdW'(amount_q) * ProdW'(tick_rate_i);
    end
    if (cmd_i.div) begin
      quo_q <= quo_d;
    end
  end

  assign prod_sat = (|prod_q[ProdW-1:TickW]) ? '1 : prod_q[TickW-1:0];

  // divide by 1000 or 1000000 as a multiply by the reciprocal and a shift
  assign recip      = (unit_q == UNIT_MS) ? RecipMs : RecipUs;
  assign recip_prod = RecipProdW'(prod_sat) * RecipProdW'(recip);
  assign quo_d      = (unit_q == UNIT_MS) ? TickW'(recip_prod >> RecipMsShift)
                                          : TickW'(recip_prod >> RecipUsShift);

  always_comb begin
    case (unit_q)
      UNIT_TICKS: ticks = amount_q;
      UNIT_SEC:   ticks = prod_sat;
      default:    ticks = quo_q;
    endcase
  end

  // lowest free handle
  always_comb begin
    free_h = '0;
    for (int h = HandleCount - 1; h >= 0; h--) begin
      if (!busy_q[h]) free_h = HandleW'(h);
    end
  end

  always_comb begin
    r_d         = r_q;
    w_d         = w_q;
    pv_d        = 1'b0;
    found_d     = found_q;
    live_d      = live_q;
    busy_d      = busy_q;
    rd_en       = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = w_q[SlotIdxW-1:0];
    mem_wdata   = rd_entry_q;
    out_valid_d = 1'b0;
    kind_d      = kind_q;
    handle_d    = handle_q;
    last_d      = last_q;

    if (cmd_i.load) begin
      r_d     = '0;
      w_d     = '0;
      found_d = 1'b0;
    end

    if (cmd_i.reject) begin
      out_valid_d = 1'b1;
      kind_d      = KIND_REJECTED;
      handle_d    = '0;
      last_d      = 1'b1;
    end

    if (cmd_i.append) begin
      mem_we           = 1'b1;
      mem_waddr        = live_q[SlotIdxW-1:0];
      mem_wdata.handle = free_h;
      mem_wdata.count  = ticks;
      live_d           = live_q + CountW'(1);
      busy_d[free_h]   = 1'b1;
      out_valid_d      = 1'b1;
      kind_d           = KIND_SCHEDULED;
      handle_d         = free_h;
      last_d           = 1'b1;
    end

    if (cmd_i.walk) begin
      // read side runs one entry ahead of the compacting write side
      if (r_q < live_q) begin
        rd_en = 1'b1;
        r_d   = r_q + CountW'(1);
        pv_d  = 1'b1;
      end
      if (pv_q) begin
        if (act_q == ACT_TICK) begin
          if (rd_entry_q.count != '0) begin
            mem_we          = 1'b1;
            mem_wdata.count = rd_entry_q.count - TickW'(1);
            w_d             = w_q + CountW'(1);
          end else begin
            busy_d[rd_entry_q.handle] = 1'b0;
            out_valid_d = 1'b1;
            kind_d      = KIND_FIRED;
            handle_d    = rd_entry_q.handle;
            last_d      = 1'b0;
          end
        end else begin
          if (!found_q && (rd_entry_q.handle == chandle_q)) begin
            found_d                   = 1'b1;
            busy_d[rd_entry_q.handle] = 1'b0;
          end else begin
            mem_we = 1'b1;
            w_d    = w_q + CountW'(1);
          end
        end
      end
    end

    if (cmd_i.finish) begin
      live_d      = w_q;
      out_valid_d = 1'b1;
      last_d      = 1'b1;
      if (act_q == ACT_TICK) begin
        kind_d   = KIND_TICK_DONE;
        handle_d = '0;
      end else if (found_q) begin
        kind_d   = KIND_CANCELLED;
        handle_d = chandle_q;
      end else begin
        kind_d   = KIND_NOT_FOUND;
        handle_d = '0;
      end
    end
  end

  // slot memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_entry_q <= mem[r_q[SlotIdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q      <= '0;
      busy_q      <= '0;
      r_q         <= '0;
      w_q         <= '0;
      pv_q        <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_TICK_DONE;
      handle_q    <= '0;
      last_q      <= 1'b0;
    end else begin
      live_q      <= live_d;
      busy_q      <= busy_d;
      r_q         <= r_d;
      w_q         <= w_d;
      pv_q        <= pv_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      kind_q      <= kind_d;
      handle_q    <= handle_d;
      last_q      <= last_d;
    end
  end

  assign sts_o.act       = act_q;
  assign sts_o.bad_unit  = unit_q[UnitW-1];
  assign sts_o.full      = (live_q >= CountW'(TimerSlots)) || (&busy_q);
  assign sts_o.need_div  = (unit_q == UNIT_MS) || (unit_q == UNIT_US);
  assign sts_o.walk_done = (r_q == live_q) && !pv_q;

  assign out_strobe_o = out_valid_q;
  assign kind_o       = kind_q;
  assign handle_o     = handle_q;
  assign last_o       = last_q;

`ifndef NO_ASSERTIONS
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= CountW'(TimerSlots))
    else $error("live count beyond table size");

  a_busy_matches_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> ($countones(busy_q) == int'(live_q)))
    else $error("handle bits disagree with live count at accept");

  a_write_behind_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk |-> (w_q <= r_q))
    else $error("compaction write pointer passed read pointer");

  a_append_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |-> ((live_q < CountW'(TimerSlots)) && !(&busy_q)))
    else $error("entry appended to a full table");
`endif

endmodule

FILE: rtl/core/tick_countdown_timer_table_unit.sv
// ----------------------------------------------------------------------------
// tick_countdown_timer_table_unit
// table of one-shot countdown timers kept in insertion order
// ----------------------------------------------------------------------------
// usage
// - request channel: a transfer happens at a clock edge with start high and
//   busy low; action_i, amount_i, unit_i and cancel_handle_i are sampled then
// - result channel: each result shows on kind_o, handle_o, last_o for one
//   cycle with out_strobe_o high; last_o marks the final result of a request
// - schedule in ticks or seconds: busy through decode, multiply and append, result follows
// - schedule in ms or us: busy as for seconds plus a divide state, the
//   divide done as a multiply by the reciprocal
// - cancel and tick: busy through decode and the slot memory walk (one entry
//   read per cycle on its single read port); a tick emits one fired result per
//   expired entry, then tick done
// - rejected requests: busy only in decode, one rejected result
// - busy drops in the cycle the final result is shown, so the next request
//   may be taken while that result is on the ports
// - reset clears the table (live count and handle bits) and loads the tick
//   rate of 24; no clearing pass is needed
// - the receiver cannot stall; results are never held back
// - tick_rate is to be written over the apb port only while the block is idle; the block does not enforce it
module tick_countdown_timer_table_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           start,
  output logic                           busy,
  input  logic [tctt_pkg::ActionW-1:0]   action_i,
  input  logic [tctt_pkg::AmountW-1:0]   amount_i,
  input  logic [tctt_pkg::UnitW-1:0]     unit_i,
  input  logic [tctt_pkg::HandleW-1:0]   cancel_handle_i,
  // result channel
  output logic                           out_strobe_o,
  output logic [tctt_pkg::KindW-1:0]     kind_o,
  output logic [tctt_pkg::HandleW-1:0]   handle_o,
  output logic                           last_o,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tctt_pkg::PaddrW-1:0]    paddr,
  input  logic [tctt_pkg::ApbDataW-1:0]  pwdata,
  output logic [tctt_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);
  import tctt_pkg::*;

  logic [TickRateW-1:0] tick_rate;
  cmd_t                 cmd;
  sts_t                 sts;

  // tick rate register
  tctt_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .tick_rate_o (tick_rate)
  );

  // sequencer: decode, convert, append or walk
  tctt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // slot memory, handle bits, unit conversion and result register
  tctt_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .tick_rate_i     (tick_rate),
    .action_i        (action_i),
    .amount_i        (amount_i),
    .unit_i          (unit_i),
    .cancel_handle_i (cancel_handle_i),
    .out_strobe_o    (out_strobe_o),
    .kind_o          (kind_o),
    .handle_o        (handle_o),
    .last_o          (last_o)
  );

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the tick countdown timer table: requests go in on
// the start/busy channel, a shadow table in the bench works out every result
// the block owes, and each strobed result is checked against
// the oldest one waiting; tick_rate is swept over the apb port between phases
// ----------------------------------------------------------------------------
module tb;
  import tctt_pkg::*;

  // run control
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 45;
  localparam int EndLimit    = 5000;

  // request code with no meaning in the block
  localparam logic [ActionW-1:0] ActUnknown = 2'd3;

  // unit conversion divisors
  localparam longint MsPerSec = 1000;
  localparam longint UsPerSec = 1000000;

  // one result as the block shows it
  typedef struct packed {
    kind_e              kind;
    logic [HandleW-1:0] handle;
    logic               last;
  } timer_event_t;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni;

  // request channel
  logic                 start;
  logic                 busy;
  logic [ActionW-1:0]   action_i;
  logic [AmountW-1:0]   amount_i;
  logic [UnitW-1:0]     unit_i;
  logic [HandleW-1:0]   cancel_handle_i;

  // result channel
  logic                 out_strobe_o;
  logic [KindW-1:0]     kind_o;
  logic [HandleW-1:0]   handle_o;
  logic                 last_o;

  // apb port
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PaddrW-1:0]    paddr;
  logic [ApbDataW-1:0]  pwdata;
  logic [ApbDataW-1:0]  prdata;
  logic                 pready;

  // shadow copy of the timer table, kept in insertion order
  logic [HandleW-1:0]   tbl_handle [TimerSlots];
  logic [TickW-1:0]     tbl_ticks  [TimerSlots];
  int                   tbl_live    = 0;
  logic [HandleCount-1:0] handle_used = '0;
  logic [TickRateW-1:0] rate_shadow = TickRateReset;

  // results still owed by the block, oldest first
  timer_event_t         due_events [$];

  int                   mismatch_count = 0;
  int                   cycle_count;
  int                   burst_left     = 0;

  tick_countdown_timer_table_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .action_i        (action_i),
    .amount_i        (amount_i),
    .unit_i          (unit_i),
    .cancel_handle_i (cancel_handle_i),
    .out_strobe_o    (out_strobe_o),
    .kind_o          (kind_o),
    .handle_o        (handle_o),
    .last_o          (last_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog: a hung handshake or a lost result ends the run here
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // shadow table
  // ---------------------------------------------------------------------------

  function automatic void push_event(input kind_e kind, input logic [HandleW-1:0] hdl,
                                     input logic last);
    timer_event_t ev;
    ev.kind   = kind;
    ev.handle = hdl;
    ev.last   = last;
    due_events = {due_events, ev};
  endfunction

  // product is saturated before the divide, ticks bypass the rate
  function automatic logic [TickW-1:0] delay_in_ticks(input logic [AmountW-1:0] amt,
                                                      input logic [UnitW-1:0] un);
    longint unsigned prod;
    prod = longint'(amt) * longint'(rate_shadow);
    if (prod > 64'hFFFF_FFFF) prod = 64'hFFFF_FFFF;
    case (un)
      UNIT_TICKS: return amt;
      UNIT_SEC:   return TickW'(prod);
      UNIT_MS:    return TickW'(prod / MsPerSec);
      default:    return TickW'(prod / UsPerSec);
    endcase
  endfunction

  // frees the handle and closes up the later entries
  function automatic void drop_entry(input int pos);
    handle_used[tbl_handle[pos]] = 1'b0;
    for (int j = pos; j + 1 < tbl_live; j++) begin
      tbl_handle[j] = tbl_handle[j + 1];
      tbl_ticks[j]  = tbl_ticks[j + 1];
    end
    tbl_live--;
  endfunction

  function automatic void apply_timer_request(input logic [ActionW-1:0] act,
                                              input logic [AmountW-1:0] amt,
                                              input logic [UnitW-1:0] un,
                                              input logic [HandleW-1:0] ch);
    int               pos;
    int               free_h;
    logic [TickW-1:0] ticks;
    pos    = 0;
    free_h = -1;
    case (act)
      ACT_SCHEDULE: begin
        ticks = delay_in_ticks(amt, un);
        for (int h = HandleCount - 1; h >= 0; h--)
          if (!handle_used[h]) free_h = h;
        if (un > UNIT_US || tbl_live >= TimerSlots || free_h < 0) begin
          push_event(KIND_REJECTED, '0, 1'b1);
        end else begin
          tbl_handle[tbl_live] = HandleW'(free_h);
          tbl_ticks[tbl_live]  = ticks;
          tbl_live++;
          handle_used[free_h] = 1'b1;
          push_event(KIND_SCHEDULED, HandleW'(free_h), 1'b1);
        end
      end
      ACT_CANCEL: begin
        while (pos < tbl_live && tbl_handle[pos] != ch) pos++;
        if (pos < tbl_live) begin
          drop_entry(pos);
          push_event(KIND_CANCELLED, ch, 1'b1);
        end else begin
          push_event(KIND_NOT_FOUND, '0, 1'b1);
        end
      end
      ACT_TICK: begin
        // zero countdown fires and leaves; the next entry slides into pos
        while (pos < tbl_live) begin
          if (tbl_ticks[pos] != '0) begin
            tbl_ticks[pos] = tbl_ticks[pos] - 1'b1;
            pos++;
          end else begin
            push_event(KIND_FIRED, tbl_handle[pos], 1'b0);
            drop_entry(pos);
          end
        end
        push_event(KIND_TICK_DONE, '0, 1'b1);
      end
      default: push_event(KIND_REJECTED, '0, 1'b1);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result checking, sampled at the edge that ends the strobe cycle
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : check_result
    timer_event_t want;
    if (rst_ni === 1'b1 && out_strobe_o === 1'b1) begin
      if (due_events.size() == 0) begin
        flag_mismatch($sformatf("result with none pending: kind %0d handle %0d last %0d",
                                kind_o, handle_o, last_o));
      end else begin
        want = due_events.pop_front();
        if (kind_o !== want.kind)
          flag_mismatch($sformatf("kind %0d, predicted %0d", kind_o, want.kind));
        if (handle_o !== want.handle)
          flag_mismatch($sformatf("handle %0d, predicted %0d (kind %0d)",
                                  handle_o, want.handle, want.kind));
        if (last_o !== want.last)
          flag_mismatch($sformatf("last %0d, predicted %0d (kind %0d)",
                                  last_o, want.last, want.kind));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // start stays high across back-to-back transfers; the shadow table moves
  // at the accepting edge
  task automatic send_request(input logic [ActionW-1:0] act, input logic [AmountW-1:0] amt,
                              input logic [UnitW-1:0] un, input logic [HandleW-1:0] ch);
    @(negedge clk_i);
    start           <= 1'b1;
    action_i        <= act;
    amount_i        <= amt;
    unit_i          <= un;
    cancel_handle_i <= ch;
    do @(posedge clk_i); while (busy !== 1'b0);
    apply_timer_request(act, amt, un, ch);
  endtask

  // bursts of random length, then a gap with junk on the idle payload
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 7);
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      start           <= 1'b0;
      action_i        <= ActionW'($urandom);
      amount_i        <= $urandom;
      unit_i          <= UnitW'($urandom);
      cancel_handle_i <= HandleW'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // the block owes nothing and has had time to settle
  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (due_events.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // setup then access phase; pready is honored though it should stay high
  task automatic apb_transfer(input logic wr, input logic [ApbDataW-1:0] wdata,
                              output logic [ApbDataW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {RegTickRate, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // junk in the upper bits must be dropped by the register
  task automatic write_tick_rate(input logic [TickRateW-1:0] rate);
    logic [ApbDataW-1:0] rd;
    wait_idle();
    apb_transfer(1'b1, {(ApbDataW - TickRateW)'($urandom), rate}, rd);
    rate_shadow = rate;
    apb_transfer(1'b0, '0, rd);
    if (rd[TickRateW-1:0] !== rate)
      flag_mismatch($sformatf("tick_rate reads %0d, written %0d", rd[TickRateW-1:0], rate));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset value of the rate and a tick on the empty table
  task automatic test_reset_defaults();
    logic [ApbDataW-1:0] rd;
    apb_transfer(1'b0, '0, rd);
    if (rd[TickRateW-1:0] !== TickRateReset)
      flag_mismatch($sformatf("tick_rate after reset reads %0d", rd[TickRateW-1:0]));
    send_request(ACT_TICK, '0, UNIT_TICKS, '0);
  endtask

  // every operation, unit extremes, saturation, zero delay, bad codes
  task automatic test_directed_ops();
    send_request(ACT_SCHEDULE, 32'd0, UNIT_TICKS, 4'hF);
    send_request(ACT_SCHEDULE, 32'hFFFF_FFFF, UNIT_TICKS, '0);
    send_request(ACT_SCHEDULE, 32'hFFFF_FFFF, UNIT_SEC, '0);
    send_request(ACT_SCHEDULE, 32'hFFFF_FFFF, UNIT_MS, '0);
    send_request(ACT_SCHEDULE, 32'hFFFF_FFFF, UNIT_US, '0);
    send_request(ACT_SCHEDULE, 32'd1, UNIT_US, '0);
    send_request(ACT_SCHEDULE, 32'd100, UNIT_MS, '0);
    send_request(ACT_SCHEDULE, 32'd1, UNIT_SEC, '0);
    // unknown unit and unknown action
    send_request(ACT_SCHEDULE, 32'd5, 3'h7, '0);
    send_request(ActUnknown, 32'hFFFF_FFFF, 3'h7, 4'hF);
    // zero-delay entries fire here, the 100 ms entry counts down then fires
    send_request(ACT_TICK, '0, UNIT_TICKS, '0);
    send_request(ACT_TICK, '0, UNIT_TICKS, '0);
    send_request(ACT_TICK, '0, UNIT_TICKS, '0);
    // cancel of a live handle, then of the same and of an unused one
    send_request(ACT_CANCEL, '0, UNIT_TICKS, 4'd1);
    send_request(ACT_CANCEL, '0, UNIT_TICKS, 4'd1);
    send_request(ACT_CANCEL, 32'hFFFF_FFFF, 3'h7, 4'hF);
  endtask

  // fill until the table refuses twice, fire a few, cancel the rest
  task automatic test_table_full();
    int spills;
    spills = 0;
    while (spills < 2) begin
      if (tbl_live == TimerSlots) spills++;
      send_request(ACT_SCHEDULE, 32'($urandom_range(0, 12)), UNIT_TICKS, HandleW'($urandom));
      pace_sender();
    end
    repeat (6) begin
      send_request(ACT_TICK, $urandom, UnitW'($urandom), HandleW'($urandom));
      pace_sender();
    end
    while (tbl_live > 0) begin
      send_request(ACT_CANCEL, $urandom, UnitW'($urandom),
                   tbl_handle[$urandom_range(0, tbl_live - 1)]);
      pace_sender();
    end
  endtask

  // mostly short well-formed timers with cancels of live handles, some noise
  task automatic random_timer_request();
    int                 pick;
    int                 rate_div;
    logic [UnitW-1:0]   un;
    logic [AmountW-1:0] amt;
    pick     = $urandom_range(0, 99);
    rate_div = (rate_shadow == '0) ? 1 : int'(rate_shadow);
    un       = UnitW'($urandom_range(0, 3));
    // amounts picked so that most timers land within a few ticks
    case (un)
      UNIT_TICKS: amt = $urandom_range(0, 6);
      UNIT_SEC:   amt = ($urandom_range(0, 3) == 0) ? 32'd1 : 32'd0;
      UNIT_MS:    amt = $urandom_range(0, 8000 / rate_div);
      default:    amt = $urandom_range(0, 8000000 / rate_div);
    endcase
    if (pick < 35)
      send_request(ACT_SCHEDULE, amt, un, HandleW'($urandom));
    else if (pick < 65)
      send_request(ACT_TICK, $urandom, UnitW'($urandom), HandleW'($urandom));
    else if (pick < 80 && tbl_live > 0)
      send_request(ACT_CANCEL, $urandom, UnitW'($urandom),
                   tbl_handle[$urandom_range(0, tbl_live - 1)]);
    else if (pick < 88)
      send_request(ACT_CANCEL, $urandom, UnitW'($urandom), HandleW'($urandom));
    else if (pick < 94)
      // full-range amount and unit: saturation, long timers, bad units
      send_request(ACT_SCHEDULE, $urandom, UnitW'($urandom), HandleW'($urandom));
    else if (pick < 97)
      send_request(ActUnknown, $urandom, UnitW'($urandom), HandleW'($urandom));
    else
      send_request(ACT_SCHEDULE, $urandom, UnitW'(UNIT_US) + UnitW'($urandom_range(1, 4)),
                   HandleW'($urandom));
  endtask

  task automatic test_random_traffic(input logic [TickRateW-1:0] rate, input int count);
    write_tick_rate(rate);
    repeat (count) begin
      random_timer_request();
      pace_sender();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin : run_tests
    int waited;
    rst_ni          = 1'b0;
    start           = 1'b0;
    action_i        = '0;
    amount_i        = '0;
    unit_i          = '0;
    cancel_handle_i = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_directed_ops();
    test_table_full();
    // rate sweep: both ends of the random range, zero, top of the register, random, round
    test_random_traffic(TickRateW'(1), 64);
    test_random_traffic(TickRateW'(10000), 64);
    test_random_traffic(TickRateW'(0), 64);
    test_random_traffic({TickRateW{1'b1}}, 64);
    test_random_traffic(TickRateW'($urandom_range(1, 10000)), 64);
    test_random_traffic(TickRateW'(1000), 64);

    // let the last results arrive, then watch for strays
    @(negedge clk_i);
    start  <= 1'b0;
    waited = 0;
    while (due_events.size() != 0 && waited < EndLimit) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (DrainCycles) @(negedge clk_i);
    if (due_events.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", due_events.size()));

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: tick_countdown_timer_table_unit.f
rtl/core/tctt_pkg.sv
rtl/core/tctt_regs.sv
rtl/core/tctt_ctrl.sv
rtl/core/tctt_dp.sv
rtl/core/tick_countdown_timer_table_unit.sv
sim/tb.sv
